// ===== rtl/core/palette_dac_pixel_mapper_unit_macros.svh =====
// Assertion macros for the palette DAC pixel mapper.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PALETTE_DAC_PIXEL_MAPPER_UNIT_MACROS_SVH
`define PALETTE_DAC_PIXEL_MAPPER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PDPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: same-cycle implication");
// next-cycle implication
`define PDPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: next-cycle implication");
`else
`define PDPM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PDPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/pdpm_pkg.sv =====
// Shared types, codes and tables of the palette DAC pixel mapper.
// No dependencies; imported by every module of the block but pdpm_ram.
package pdpm_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int BYTE_CODES = 256;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// item operations
	localparam logic [1:0] OP_SET_PTR = 2'd0;
	localparam logic [1:0] OP_COLOUR  = 2'd1;
	localparam logic [1:0] OP_PIX_PAL = 2'd2;
	localparam logic [1:0] OP_PIX_DIR = 2'd3;

	// DAC register offsets
	localparam logic [3:0] OFFS_INDEX = 4'd0;
	localparam logic [3:0] OFFS_DATA  = 4'd4;

	localparam logic [7:0] DIRECT_CTRL = 8'd3;

	// configuration register indexes
	localparam logic REG_TCE = 1'b0;
	localparam logic REG_BGR = 1'b1;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  byte_val;   // pointer, colour byte or palette index
		logic [23:0] word;       // direct colour word
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// byte code -> palette slot (code modulo entry count)
	typedef logic [IDX_W-1:0] slot_tbl_t [BYTE_CODES];

	function automatic slot_tbl_t build_slot_table();
		slot_tbl_t t;
		for (int i = 0; i < BYTE_CODES; i++) begin
			t[i] = IDX_W'(i % PALETTE_ENTRIES);
		end
		return t;
	endfunction

	localparam slot_tbl_t SLOT_TABLE = build_slot_table();

endpackage

// ===== rtl/core/pdpm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pdpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/pdpm_front.sv =====
// Front end: accepts input beats, classifies them and feeds the queue.
// Depends on pdpm_pkg.
module pdpm_front (
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 mode,
	input  logic [3:0]           reg_offset,
	input  logic [31:0]          write_data,
	input  logic [7:0]           palette_index,
	input  logic [23:0]          direct_word,
	input  logic [7:0]           control_byte,
	input  logic                 true_color_enable,
	input  pdpm_pkg::q_status_t  q_status,
	output logic                 push,
	output pdpm_pkg::item_t      push_item
);
	import pdpm_pkg::*;

	logic keep;

	always_comb begin
		keep = 1'b1;
		push_item.word = direct_word;
		if (mode) begin
			push_item.byte_val = palette_index;
			push_item.op = (true_color_enable && control_byte == DIRECT_CTRL) ?
				OP_PIX_DIR : OP_PIX_PAL;
		end else begin
			push_item.byte_val = write_data[31:24];
			case (reg_offset)
				OFFS_INDEX: push_item.op = OP_SET_PTR;
				OFFS_DATA:  push_item.op = OP_COLOUR;
				default: begin
					// unmapped offset: beat is consumed and dropped
					push_item.op = OP_SET_PTR;
					keep = 1'b0;
				end
			endcase
		end
	end

	assign req_ready = !q_status.full;
	assign push = req_valid && req_ready && keep;

endmodule

// ===== rtl/core/pdpm_queue.sv =====
// Short FIFO of classified items between front and back.
// Depends on pdpm_pkg.
module pdpm_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pdpm_pkg::item_t      push_item,
	input  logic                 pop,
	output pdpm_pkg::item_t      head,
	output pdpm_pkg::q_status_t  status
);
	import pdpm_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

// ===== rtl/core/pdpm_back.sv =====
// Back end: DAC pointer and colour phase, palette planes, pixel output.
// Depends on pdpm_pkg and pdpm_ram.
module pdpm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pdpm_pkg::item_t      head,
	input  pdpm_pkg::q_status_t  q_status,
	output logic                 pop,
	input  logic                 bgr_order,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [23:0]          pixel_value,
	output logic                 direct_used
);
	import pdpm_pkg::*;

	localparam logic [1:0] PH_RED   = 2'd0;
	localparam logic [1:0] PH_GREEN = 2'd1;
	localparam logic [1:0] PH_BLUE  = 2'd2;

	logic [7:0]                 ptr_q;
	logic [1:0]                 phase_q;
	logic [PALETTE_ENTRIES-1:0] valid_q;

	logic             valid_s1;
	logic             direct_s1;
	logic             hit_s1;
	logic             last_s1;
	logic [23:0]      word_s1;

	logic             head_pix;
	logic             do_colour;
	logic             rd_pal;
	logic [IDX_W-1:0] wslot;
	logic [IDX_W-1:0] rslot;
	logic [7:0]       wdefault;
	logic             we_r;
	logic             we_g;
	logic             we_b;
	logic [7:0]       wd_g;
	logic [7:0]       wd_b;
	logic [7:0]       rd_r;
	logic [7:0]       rd_g;
	logic [7:0]       rd_b;
	logic [7:0]       px_r;
	logic [7:0]       px_g;
	logic [7:0]       px_b;
	logic [7:0]       dflt_s1;

	assign head_pix = (head.op == OP_PIX_PAL) || (head.op == OP_PIX_DIR);
	// writes never wait on the output; pixels wait for a free result slot
	assign pop = !q_status.empty && (!head_pix || !valid_s1 || rsp_ready);
	assign do_colour = pop && (head.op == OP_COLOUR);
	assign rd_pal = pop && (head.op == OP_PIX_PAL);

	assign wslot = SLOT_TABLE[ptr_q];
	assign rslot = SLOT_TABLE[head.byte_val];
	assign wdefault = (wslot == IDX_W'(PALETTE_ENTRIES - 1)) ? 8'hFF : 8'h00;

	// green and blue only ever follow red on the same slot, so the red
	// write is the one that materializes an untouched entry
	always_comb begin
		we_r = 1'b0;
		we_g = 1'b0;
		we_b = 1'b0;
		wd_g = head.byte_val;
		wd_b = head.byte_val;
		if (do_colour) begin
			case (phase_q)
				PH_RED: begin
					we_r = 1'b1;
					if (!valid_q[wslot]) begin
						we_g = 1'b1;
						we_b = 1'b1;
						wd_g = wdefault;
						wd_b = wdefault;
					end
				end
				PH_GREEN: we_g = 1'b1;
				PH_BLUE:  we_b = 1'b1;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			phase_q  <= PH_RED;
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pop && head.op == OP_SET_PTR) begin
				ptr_q   <= head.byte_val;
				phase_q <= PH_RED;
			end else if (do_colour) begin
				case (phase_q)
					PH_RED: begin
						phase_q        <= PH_GREEN;
						valid_q[wslot] <= 1'b1;
					end
					PH_GREEN: phase_q <= PH_BLUE;
					PH_BLUE: begin
						phase_q <= PH_RED;
						ptr_q   <= ptr_q + 8'd1;
					end
					default: phase_q <= PH_RED;
				endcase
			end
			if (pop && head_pix) begin
				valid_s1 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_pix) begin
			direct_s1 <= (head.op == OP_PIX_DIR);
			word_s1   <= head.word;
			hit_s1    <= valid_q[rslot];
			last_s1   <= (rslot == IDX_W'(PALETTE_ENTRIES - 1));
		end
	end

	pdpm_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_red (
		.clk(clk), .we(we_r), .waddr(wslot), .wdata(head.byte_val),
		.re(rd_pal), .raddr(rslot), .rdata(rd_r)
	);

	pdpm_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_green (
		.clk(clk), .we(we_g), .waddr(wslot), .wdata(wd_g),
		.re(rd_pal), .raddr(rslot), .rdata(rd_g)
	);

	pdpm_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_blue (
		.clk(clk), .we(we_b), .waddr(wslot), .wdata(wd_b),
		.re(rd_pal), .raddr(rslot), .rdata(rd_b)
	);

	assign dflt_s1 = last_s1 ? 8'hFF : 8'h00;

	always_comb begin
		if (direct_s1) begin
			px_r = word_s1[7:0];
			px_g = word_s1[15:8];
			px_b = word_s1[23:16];
		end else if (hit_s1) begin
			px_r = rd_r;
			px_g = rd_g;
			px_b = rd_b;
		end else begin
			px_r = dflt_s1;
			px_g = dflt_s1;
			px_b = dflt_s1;
		end
	end

	assign rsp_valid   = valid_s1;
	assign pixel_value = bgr_order ? {px_b, px_g, px_r} : {px_r, px_g, px_b};
	assign direct_used = direct_s1;

endmodule

// ===== rtl/core/palette_dac_pixel_mapper_unit.sv =====
// Top level of the palette DAC pixel mapper: config registers and wiring.
// Depends on pdpm_pkg, pdpm_front, pdpm_queue, pdpm_back and the macro header.
//
//   channel   signals                          beat moves
//   -------   -------------------------------  ---------------------------------
//   cfg       psel/penable/pwrite/paddr/...    one register write or read
//   req       req_valid/req_ready + fields     one DAC write or one pixel
//   rsp       rsp_valid/rsp_ready + fields     one packed host pixel
//
// Sustained rate is one req beat per cycle while no pixel waits on rsp; a
// pixel passes the queue slot, then the palette plane registered read, before
// its result is offered on rsp.
// DAC writes and dropped offsets produce no rsp beat; writes wait only behind a waiting pixel.
// Reset needs no clearing pass: a per-entry valid bit makes untouched entries
// read as black, the last one as white.
// A stalled rsp holds the pixel; DAC writes behind it still retire until another
// pixel reaches the queue head, and req_ready drops once the two-entry queue fills.
`include "palette_dac_pixel_mapper_unit_macros.svh"

module palette_dac_pixel_mapper_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        mode,
	input  logic [3:0]  reg_offset,
	input  logic [31:0] write_data,
	input  logic [7:0]  palette_index,
	input  logic [23:0] direct_word,
	input  logic [7:0]  control_byte,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [23:0] pixel_value,
	output logic        direct_used
);
	import pdpm_pkg::*;

	logic      tce_q;
	logic      bgr_q;
	logic      cfg_wr;
	logic      q_push;
	logic      q_pop;
	item_t     push_item;
	item_t     q_head;
	q_status_t q_status;

	// register index is paddr[2]; byte lanes below it are not decoded
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tce_q <= 1'b0;
			bgr_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_TCE: tce_q <= pwdata[0];
				REG_BGR: bgr_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TCE: prdata = {31'd0, tce_q};
			REG_BGR: prdata = {31'd0, bgr_q};
			default: prdata = 32'd0;
		endcase
	end

	// front: handshake and classification (direct vs palette decided here)
	pdpm_front u_front (
		.req_valid(req_valid), .req_ready(req_ready), .mode(mode),
		.reg_offset(reg_offset), .write_data(write_data),
		.palette_index(palette_index), .direct_word(direct_word),
		.control_byte(control_byte), .true_color_enable(tce_q),
		.q_status(q_status), .push(q_push), .push_item(push_item)
	);

	pdpm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_item(push_item),
		.pop(q_pop), .head(q_head), .status(q_status)
	);

	// back: DAC state, palette planes, output stage and byte order
	pdpm_back u_back (
		.clk(clk), .arst_n(arst_n), .head(q_head), .q_status(q_status),
		.pop(q_pop), .bgr_order(bgr_q), .rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready), .pixel_value(pixel_value),
		.direct_used(direct_used)
	);

	`PDPM_ASSERT_NOW(a_no_push_full, clk, arst_n, q_push, !q_status.full)
	`PDPM_ASSERT_NOW(a_no_pop_empty, clk, arst_n, q_pop, !q_status.empty)
	`PDPM_ASSERT_NOW(a_rsp_from_pop, clk, arst_n, $rose(rsp_valid), $past(q_pop))

endmodule
